### rtl/core/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, codes and constants for the running sample statistics block.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Parameter defaults
  localparam int unsigned DefSampleBits   = 16;
  localparam int unsigned DefCountBits    = 32;
  localparam int unsigned DefFractionBits = 8;

  // Fixed field and accumulator widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SumW    = 48;
  localparam int unsigned SqSumW  = 64;
  localparam int unsigned JitW    = 48;
  localparam int unsigned MeanW   = 24;
  localparam int unsigned VarW    = 40;
  localparam int unsigned DevW    = 24;

  // Iteration counts of the shared arithmetic units
  localparam int unsigned MulSteps  = 64;
  localparam int unsigned DivSteps  = 128;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned StepW     = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_ADD   = 2'd1,
    ACC_CLEAR = 2'd2
  } acc_op_e;

  typedef enum logic [2:0] {
    CO_NONE  = 3'd0,
    CO_CLR   = 3'd1,
    CO_LOAD  = 3'd2,
    CO_STEP  = 3'd3,
    CO_STORE = 3'd4,
    CO_SUB   = 3'd5,
    CO_OUT   = 3'd6
  } calc_op_e;

  typedef enum logic [2:0] {
    PH_DIVM = 3'd0,
    PH_MULA = 3'd1,
    PH_MULB = 3'd2,
    PH_MULN = 3'd3,
    PH_DIVV = 3'd4,
    PH_DIVD = 3'd5,
    PH_SQRT = 3'd6
  } phase_e;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [SampleW-1:0] sample;
  } rss_in_t;

  typedef struct packed {
    logic [CountW-1:0]  sample_count;
    logic [SampleW-1:0] minimum;
    logic [SampleW-1:0] maximum;
    logic [SumW-1:0]    total;
    logic [JitW-1:0]    jitter_sum;
    logic [SampleW-1:0] previous_sample;
    logic [MeanW-1:0]   mean_q8;
    logic [VarW-1:0]    variance_q8;
    logic [DevW-1:0]    deviation_q8;
    logic               overflowed;
  } rss_out_t;

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic [SampleW-1:0] minimum;
    logic [SampleW-1:0] maximum;
    logic [SampleW-1:0] last;
    logic [SumW-1:0]    total;
    logic [SqSumW-1:0]  sq_sum;
    logic [JitW-1:0]    jitter;
    logic               overflow;
  } rss_stats_t;

  typedef struct packed {
    acc_op_e  acc_op;
    calc_op_e op;
    phase_e   ph;
  } rss_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic neg;
  } rss_sts_t;

  // Clamp to the largest value of a w-bit field
  function automatic logic [63:0] sat_u(logic [63:0] v, int unsigned w);
    logic [63:0] mx;
    mx = (64'd1 << w) - 64'd1;
    return (v > mx) ? mx : v;
  endfunction

endpackage

### rtl/core/rss_in_if.sv
// ----------------------------------------------------------------------------
// rss_in_if
// Request channel: command and sample with valid/ready.
// ----------------------------------------------------------------------------
interface rss_in_if
  import rss_pkg::*;
();
  logic    valid;
  logic    ready;
  rss_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rss_out_if.sv
// ----------------------------------------------------------------------------
// rss_out_if
// Report channel: statistics result with valid/ready.
// ----------------------------------------------------------------------------
interface rss_out_if
  import rss_pkg::*;
();
  logic     valid;
  logic     ready;
  rss_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rss_acc.sv
// ----------------------------------------------------------------------------
// rss_acc
// Running accumulators: count, sum, sum of squares, extremes, jitter.
// ----------------------------------------------------------------------------
module rss_acc
  import rss_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DefSampleBits,
  parameter int unsigned COUNT_BITS  = DefCountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acc_op_e            acc_op_i,
  input  logic [SampleW-1:0] sample_i,
  output rss_stats_t         stats_o
);

  localparam logic [SampleW-1:0] SampleMask = SampleW'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [SqSumW-1:0]     sq_q, sq_d;
  logic [SampleW-1:0]    min_q, min_d, max_q, max_d, last_q, last_d;
  logic [JitW-1:0]       jit_q, jit_d;
  logic                  ovf_q, ovf_d;

  logic [SampleW-1:0]    x;
  logic [SampleW-1:0]    absd;
  logic [2*SampleW-1:0]  x_sq;

  assign x    = sample_i & SampleMask;
  assign absd = (last_q > x) ? (last_q - x) : (x - last_q);
  assign x_sq = x * x;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    min_d   = min_q;
    max_d   = max_q;
    last_d  = last_q;
    jit_d   = jit_q;
    ovf_d   = ovf_q;
    unique case (acc_op_i)
      ACC_CLEAR: begin
        count_d = '0;
        sum_d   = '0;
        sq_d    = '0;
        min_d   = '0;
        max_d   = '0;
        last_d  = '0;
        jit_d   = '0;
        ovf_d   = 1'b0;
      end
      ACC_ADD: begin
        if (&count_q) begin
          ovf_d = 1'b1;
        end else begin
          if (count_q == '0) begin
            min_d = x;
            max_d = x;
          end else begin
            jit_d = jit_q + JitW'(absd);
            if (x < min_q) min_d = x;
            if (x > max_q) max_d = x;
          end
          last_d  = x;
          sum_d   = sum_q + SumW'(x);
          sq_d    = sq_q + SqSumW'(x_sq);
          count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      min_q   <= '0;
      max_q   <= '0;
      last_q  <= '0;
      jit_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      min_q   <= min_d;
      max_q   <= max_d;
      last_q  <= last_d;
      jit_q   <= jit_d;
      ovf_q   <= ovf_d;
    end
  end

  assign stats_o.count    = CountW'(count_q);
  assign stats_o.minimum  = min_q;
  assign stats_o.maximum  = max_q;
  assign stats_o.last     = last_q;
  assign stats_o.total    = sum_q;
  assign stats_o.sq_sum   = sq_q;
  assign stats_o.jitter   = jit_q;
  assign stats_o.overflow = ovf_q;

endmodule

### rtl/core/rss_calc.sv
// ----------------------------------------------------------------------------
// rss_calc
// Report datapath: shift-add multiplier, restoring divider and bit-pair
// square root, plus the result register.
// ----------------------------------------------------------------------------
module rss_calc
  import rss_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = DefFractionBits
) (
  input  logic       clk_i,
  input  rss_cmd_t   cmd_i,
  input  rss_stats_t stats_i,
  output rss_sts_t   sts_o,
  output rss_out_t   out_o
);

  localparam logic [63:0] SqrtTop = {2'b01, 62'd0};

  // multiplier
  logic [127:0] mul_acc_q;
  logic [63:0]  mul_cand_q, mul_plier_q;
  // divider
  logic [127:0] div_num_q;
  logic [63:0]  div_rem_q, div_den_q, div_quo_q;
  // square root
  logic [63:0]  sq_x_q, sq_res_q, sq_bit_q;
  // intermediates and results
  logic [95:0]  a_q, b_q, diff_q;
  logic [63:0]  nn_q;
  logic         neg_q;
  logic [MeanW-1:0] mean_q;
  logic [VarW-1:0]  var_q;
  logic [DevW-1:0]  dev_q;
  rss_out_t     out_q;

  logic [63:0]  n64, sum64, sum_sh;
  logic [127:0] diff_w;
  logic [64:0]  rem_sh;
  logic         rem_ge;
  logic [63:0]  sq_try;
  logic [96:0]  sub_w;

  assign n64    = 64'(stats_i.count);
  assign sum64  = 64'(stats_i.total);
  assign sum_sh = sum64 << FRACTION_BITS;
  assign diff_w = {32'd0, diff_q};
  assign rem_sh = {div_rem_q, div_num_q[127]};
  assign rem_ge = rem_sh >= {1'b0, div_den_q};
  assign sq_try = sq_res_q + sq_bit_q;
  assign sub_w  = {1'b0, a_q} - {1'b0, b_q};

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CO_CLR: begin
        mean_q <= '0;
        var_q  <= '0;
        dev_q  <= '0;
        neg_q  <= 1'b0;
      end
      CO_LOAD: begin
        mul_acc_q <= '0;
        div_rem_q <= '0;
        div_quo_q <= '0;
        unique case (cmd_i.ph)
          PH_DIVM: begin
            div_num_q <= {64'd0, sum_sh};
            div_den_q <= n64;
          end
          PH_MULA: begin
            mul_cand_q  <= stats_i.sq_sum;
            mul_plier_q <= n64;
          end
          PH_MULB: begin
            mul_cand_q  <= sum64;
            mul_plier_q <= sum64;
          end
          PH_MULN: begin
            mul_cand_q  <= n64;
            mul_plier_q <= n64;
          end
          PH_DIVV: begin
            div_num_q <= diff_w << FRACTION_BITS;
            div_den_q <= nn_q;
          end
          PH_DIVD: begin
            div_num_q <= diff_w << (2 * FRACTION_BITS);
            div_den_q <= nn_q;
          end
          PH_SQRT: begin
            sq_x_q   <= div_quo_q;
            sq_res_q <= '0;
            sq_bit_q <= SqrtTop;
          end
          default: ;
        endcase
      end
      CO_STEP: begin
        unique case (cmd_i.ph)
          PH_MULA, PH_MULB, PH_MULN: begin
            mul_acc_q   <= {mul_acc_q[126:0], 1'b0}
                           + (mul_plier_q[63] ? {64'd0, mul_cand_q} : 128'd0);
            mul_plier_q <= {mul_plier_q[62:0], 1'b0};
          end
          PH_DIVM, PH_DIVV, PH_DIVD: begin
            div_num_q <= {div_num_q[126:0], 1'b0};
            div_rem_q <= rem_ge ? 64'(rem_sh - {1'b0, div_den_q}) : rem_sh[63:0];
            div_quo_q <= {div_quo_q[62:0], rem_ge};
          end
          PH_SQRT: begin
            if (sq_x_q >= sq_try) begin
              sq_x_q   <= sq_x_q - sq_try;
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else begin
              sq_res_q <= sq_res_q >> 1;
            end
            sq_bit_q <= sq_bit_q >> 2;
          end
          default: ;
        endcase
      end
      CO_STORE: begin
        unique case (cmd_i.ph)
          PH_DIVM: mean_q <= MeanW'(sat_u(div_quo_q, MeanW));
          PH_MULA: a_q    <= mul_acc_q[95:0];
          PH_MULB: b_q    <= mul_acc_q[95:0];
          PH_MULN: nn_q   <= mul_acc_q[63:0];
          PH_DIVV: var_q  <= VarW'(sat_u(div_quo_q, VarW));
          PH_SQRT: dev_q  <= DevW'(sat_u(sq_res_q, DevW));
          default: ;
        endcase
      end
      CO_SUB: begin
        diff_q <= sub_w[95:0];
        neg_q  <= sub_w[96];
      end
      CO_OUT: begin
        out_q.sample_count    <= stats_i.count;
        out_q.minimum         <= stats_i.minimum;
        out_q.maximum         <= stats_i.maximum;
        out_q.total           <= stats_i.total;
        out_q.jitter_sum      <= stats_i.jitter;
        out_q.previous_sample <= stats_i.last;
        out_q.mean_q8         <= mean_q;
        out_q.variance_q8     <= var_q;
        out_q.deviation_q8    <= dev_q;
        out_q.overflowed      <= stats_i.overflow;
      end
      default: ;
    endcase
  end

  assign sts_o.count_zero = (stats_i.count == '0);
  assign sts_o.neg        = neg_q;
  assign out_o            = out_q;

endmodule

### rtl/core/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer: accepts requests, steps the report datapath phase by phase and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module rss_ctrl
  import rss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [CmdW-1:0] in_cmd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rss_sts_t        sts_i,
  output rss_cmd_t        cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_START = 11'b000_0000_0010,
    S_DIVM  = 11'b000_0000_0100,
    S_MULA  = 11'b000_0000_1000,
    S_MULB  = 11'b000_0001_0000,
    S_MULN  = 11'b000_0010_0000,
    S_SUB   = 11'b000_0100_0000,
    S_DIVV  = 11'b000_1000_0000,
    S_DIVD  = 11'b001_0000_0000,
    S_SQRT  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  logic             is_phase;
  phase_e           ph;
  logic [StepW-1:0] steps;
  state_e           nxt;

  always_comb begin
    is_phase = 1'b1;
    ph       = PH_DIVM;
    steps    = StepW'(DivSteps);
    nxt      = S_IDLE;
    unique case (state_q)
      S_DIVM: begin ph = PH_DIVM; steps = StepW'(DivSteps);  nxt = S_MULA; end
      S_MULA: begin ph = PH_MULA; steps = StepW'(MulSteps);  nxt = S_MULB; end
      S_MULB: begin ph = PH_MULB; steps = StepW'(MulSteps);  nxt = S_MULN; end
      S_MULN: begin ph = PH_MULN; steps = StepW'(MulSteps);  nxt = S_SUB;  end
      S_DIVV: begin ph = PH_DIVV; steps = StepW'(DivSteps);  nxt = S_DIVD; end
      S_DIVD: begin ph = PH_DIVD; steps = StepW'(DivSteps);  nxt = S_SQRT; end
      S_SQRT: begin ph = PH_SQRT; steps = StepW'(SqrtSteps); nxt = S_OUT;  end
      default: is_phase = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cmd_o.acc_op = ACC_NONE;
    cmd_o.op     = CO_NONE;
    cmd_o.ph     = ph;
    in_ready_o   = (state_q == S_IDLE);

    if (is_phase) begin
      // count 0 loads, 1..steps iterate, then the result is stored
      if (cnt_q == '0) begin
        if (state_q == S_DIVV && sts_i.neg) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = CO_LOAD;
          cnt_d    = cnt_q + 1'b1;
        end
      end else if (cnt_q <= steps) begin
        cmd_o.op = CO_STEP;
        cnt_d    = cnt_q + 1'b1;
      end else begin
        cmd_o.op = CO_STORE;
        cnt_d    = '0;
        state_d  = nxt;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (in_cmd_i)
              CMD_ADD:    cmd_o.acc_op = ACC_ADD;
              CMD_CLEAR:  cmd_o.acc_op = ACC_CLEAR;
              CMD_REPORT: state_d      = S_START;
              default: ;
            endcase
          end
        end
        S_START: begin
          cmd_o.op = CO_CLR;
          cnt_d    = '0;
          state_d  = sts_i.count_zero ? S_OUT : S_DIVM;
        end
        S_SUB: begin
          cmd_o.op = CO_SUB;
          cnt_d    = '0;
          state_d  = S_DIVV;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            cmd_o.op    = CO_OUT;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/running_sample_statistics_top.sv
// ----------------------------------------------------------------------------
// running_sample_statistics_top
// Running count, sum, sum of squares, min/max and jitter over a sample
// stream, with mean, variance and standard deviation on report.
//
//   channel  dir  payload                                     handshake
//   in_i     in   command, sample                             valid/ready
//   out_o    out  totals, mean_q8, variance_q8, deviation_q8  valid/ready
//
// Add and clear may arrive back to back.
// A report runs the sequencer through one divide for the mean, three
// 64-step shift-add multiplies, two 128-step divides and a 32-step square
// root; with empty statistics it goes straight to the result.
// Requests are taken again once the result sits in the output register;
// a further report waits there while the previous result is not taken.
// Reset clears all statistics at once.
// ----------------------------------------------------------------------------
module running_sample_statistics_top
  import rss_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = DefSampleBits,
  parameter int unsigned COUNT_BITS    = DefCountBits,
  parameter int unsigned FRACTION_BITS = DefFractionBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rss_in_if.sink        in_i,
  rss_out_if.source     out_o
);

  rss_cmd_t   cmd;
  rss_sts_t   sts;
  rss_stats_t acc_stats;

  rss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.data.command),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rss_acc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_op_i (cmd.acc_op),
    .sample_i (in_i.data.sample),
    .stats_o  (acc_stats)
  );

  rss_calc #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_calc (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .stats_i (acc_stats),
    .sts_o   (sts),
    .out_o   (out_o.data)
  );

`ifndef SYNTH
  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.data.command == CMD_REPORT) |=> !in_i.ready)
    else $error("report request did not make the block busy");

  a_stats_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |=> $stable(acc_stats.count) && $stable(acc_stats.total))
    else $error("statistics changed during a report");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.minimum <= out_o.data.maximum))
    else $error("reported minimum above maximum");
`endif

endmodule

### verif/running_sample_statistics_top_tb.sv
// ----------------------------------------------------------------------------
// running_sample_statistics_top_tb
// Self-checking bench for the running sample statistics block. Requests
// (add, clear, report, unused code) go in in random bursts. Each report is
// predicted from a local copy of the accumulators and compared field by
// field with the result, under random and long output back-pressure.
// ----------------------------------------------------------------------------
module running_sample_statistics_top_tb
  import rss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits  = DefFractionBits;
  localparam int unsigned IdleLimit = 10000;
  localparam int unsigned DrainWait = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rss_in_if  req_if ();
  rss_out_if rep_if ();

  running_sample_statistics_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rep_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted accumulators
  logic [CountW-1:0]  st_count;
  logic [SampleW-1:0] st_min, st_max, st_last;
  logic [SumW-1:0]    st_total;
  logic [SqSumW-1:0]  st_sq;
  logic [JitW-1:0]    st_jitter;
  logic               st_ovf;

  rss_in_t  pending_reqs[$];
  rss_out_t expected_reports[$];
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  longint unsigned cycle_cnt = 0;

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    n_errors++;
  endtask

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] clamp(logic [63:0] v, int unsigned w);
    logic [63:0] mx;
    mx = (64'd1 << w) - 64'd1;
    return (v > mx) ? mx : v;
  endfunction

  task automatic clear_stats();
    st_count = 0; st_min = 0; st_max = 0; st_last = 0;
    st_total = 0; st_sq = 0; st_jitter = 0; st_ovf = 0;
  endtask

  // Apply one accepted request to the predicted state
  task automatic predict_request(rss_in_t req);
    logic [SampleW-1:0] x;
    logic [127:0] a, b, diff, nn;
    logic [63:0] q, r, mean, var_v, dev;
    rss_out_t rep;
    x = req.sample;
    case (req.command)
      CMD_ADD: begin
        if (st_count == '1) begin
          st_ovf = 1'b1;
        end else begin
          if (st_count == 0) begin
            st_min = x; st_max = x;
          end else begin
            st_jitter = st_jitter + ((st_last > x) ? st_last - x : x - st_last);
            if (x < st_min) st_min = x;
            if (x > st_max) st_max = x;
          end
          st_last = x;
          st_total = st_total + x;
          st_sq = st_sq + 64'(x) * 64'(x);
          st_count = st_count + 1;
        end
      end
      CMD_CLEAR: clear_stats();
      CMD_REPORT: begin
        mean = 0; var_v = 0; dev = 0;
        if (st_count != 0) begin
          q = 64'(st_total) / 64'(st_count);
          r = 64'(st_total) % 64'(st_count);
          mean = (q << FracBits) + ((r << FracBits) / 64'(st_count));
          a = 128'(st_count) * 128'(st_sq);
          b = 128'(st_total) * 128'(st_total);
          if (a >= b) begin
            diff = a - b;
            nn = 128'(64'(st_count) * 64'(st_count));
            var_v = 64'((diff << FracBits) / nn);
            dev = isqrt(64'((diff << (2 * FracBits)) / nn));
          end
        end
        rep.sample_count    = st_count;
        rep.minimum         = st_min;
        rep.maximum         = st_max;
        rep.total           = st_total;
        rep.jitter_sum      = st_jitter;
        rep.previous_sample = st_last;
        rep.mean_q8         = MeanW'(clamp(mean, MeanW));
        rep.variance_q8     = VarW'(clamp(var_v, VarW));
        rep.deviation_q8    = DevW'(clamp(dev, DevW));
        rep.overflowed      = st_ovf;
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  function automatic rss_in_t mk_req(logic [CmdW-1:0] cmd, logic [SampleW-1:0] s);
    rss_in_t r;
    r.command = cmd;
    r.sample = s;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SampleW'($urandom_range(0, 15));
      1: return 16'hFFFF - SampleW'($urandom_range(0, 15));
      2: return SampleW'($urandom_range(1000, 1100));
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Sender: bursts with random gaps
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) void'(pending_reqs.pop_front());
      if (!(req_if.valid && !req_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_reqs[0];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stretches of random stalls, one long hold-off
  int unsigned hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_if.ready <= 1'b0;
    end else begin
      if (cycle_cnt == 3000) hold_left = 2000;
      if (hold_left > 0) begin
        hold_left--;
        rep_if.ready <= 1'b0;
      end else if (cycle_cnt[9]) begin
        rep_if.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        rep_if.ready <= 1'b1;
      end
    end
  end

  // Monitor and predictor
  rss_out_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if ((req_if.valid && req_if.ready) || (rep_if.valid && rep_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (req_if.valid && req_if.ready) predict_request(req_if.data);
      if (rep_if.valid && rep_if.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected report", 64'd1, 64'd0);
        end else begin
          want = expected_reports.pop_front();
          if (rep_if.data.sample_count != want.sample_count)
            report_mismatch("sample_count", rep_if.data.sample_count, want.sample_count);
          if (rep_if.data.minimum != want.minimum)
            report_mismatch("minimum", rep_if.data.minimum, want.minimum);
          if (rep_if.data.maximum != want.maximum)
            report_mismatch("maximum", rep_if.data.maximum, want.maximum);
          if (rep_if.data.total != want.total)
            report_mismatch("total", rep_if.data.total, want.total);
          if (rep_if.data.jitter_sum != want.jitter_sum)
            report_mismatch("jitter_sum", rep_if.data.jitter_sum, want.jitter_sum);
          if (rep_if.data.previous_sample != want.previous_sample)
            report_mismatch("previous_sample", rep_if.data.previous_sample,
                            want.previous_sample);
          if (rep_if.data.mean_q8 != want.mean_q8)
            report_mismatch("mean_q8", rep_if.data.mean_q8, want.mean_q8);
          if (rep_if.data.variance_q8 != want.variance_q8)
            report_mismatch("variance_q8", rep_if.data.variance_q8, want.variance_q8);
          if (rep_if.data.deviation_q8 != want.deviation_q8)
            report_mismatch("deviation_q8", rep_if.data.deviation_q8, want.deviation_q8);
          if (rep_if.data.overflowed != want.overflowed)
            report_mismatch("overflowed", rep_if.data.overflowed, want.overflowed);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned n_items, len;
    clear_stats();
    // Directed: empty report, extremes, single sample, clear, unused code
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'hFFFF));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'hFFFF));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'hFFFF));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    pending_reqs.push_back(mk_req(2'd3, 16'h1234));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'hAAAA));
    pending_reqs.push_back(mk_req(CMD_CLEAR, 16'h5555));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'h0007));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'h0007));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'h0007));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_CLEAR, 16'h0000));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'h0001));
    pending_reqs.push_back(mk_req(CMD_ADD, 16'h0002));
    pending_reqs.push_back(mk_req(CMD_REPORT, 16'h0000));
    // Random: mostly clear / adds / report sequences, some noise
    n_items = 0;
    while (n_items < 1100) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 2) == 0)
          pending_reqs.push_back(mk_req(CMD_CLEAR, SampleW'($urandom)));
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 12);
        repeat (len) pending_reqs.push_back(mk_req(CMD_ADD, rand_sample()));
        pending_reqs.push_back(mk_req(CMD_REPORT, SampleW'($urandom)));
        n_items += len + 1;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          pending_reqs.push_back(mk_req(CmdW'($urandom_range(0, 3)), SampleW'($urandom)));
          n_items++;
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_reports.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_errors == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rss_pkg.sv
rtl/core/rss_in_if.sv
rtl/core/rss_out_if.sv
rtl/core/rss_acc.sv
rtl/core/rss_calc.sv
rtl/core/rss_ctrl.sv
rtl/core/running_sample_statistics_top.sv
verif/running_sample_statistics_top_tb.sv
